>>> src/hbox_pkg.sv
`timescale 1ns / 1ps

package hbox_pkg;

    localparam int MAX_COLUMNS_DEF = 1024;

    localparam int SAMPLE_W   = 8;
    localparam int LINE_W     = 2 * SAMPLE_W;   // {upper, middle} per column
    localparam int MEAN_W     = 16;
    localparam int COLS_REG_W = 11;
    localparam int ROWS_REG_W = 16;
    localparam int ROW_CNT_W  = ROWS_REG_W + 1; // runs one row past the grid while draining
    localparam int SUM_W      = 12;             // 9 * 255 fits
    localparam int COUNT_W    = 4;
    localparam int FRAC_W     = 8;
    localparam int NUM_W      = SUM_W + FRAC_W;
    localparam int RECIP_W    = 25;
    localparam int RECIP_SHIFT = 24;

    localparam int QUEUE_DEPTH = 4;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic REG_GRID_COLUMNS = 1'b0;
    localparam logic REG_GRID_ROWS    = 1'b1;

    localparam logic [COLS_REG_W-1:0] GRID_COLUMNS_RST = 11'd257;
    localparam logic [ROWS_REG_W-1:0] GRID_ROWS_RST    = 16'd257;

    localparam logic [MEAN_W-1:0] MEAN_MAX = 16'd65280;

    // Window control per advance: which neighbours take part and what to emit.
    typedef struct packed {
        logic emit;
        logic last;
        logic row_up;
        logic row_dn;
        logic col_lt;
        logic col_rt;
    } t_opflags;

    // ceil(2^24 / n) for every count the window can produce; exact for
    // numerators below 2^20.
    function automatic logic [RECIP_W-1:0] recip(input logic [COUNT_W-1:0] cnt);
        logic [RECIP_W-1:0] r;
        unique case (cnt)
            4'd1:    r = 25'd16777216;
            4'd2:    r = 25'd8388608;
            4'd3:    r = 25'd5592406;
            4'd4:    r = 25'd4194304;
            4'd6:    r = 25'd2796203;
            4'd9:    r = 25'd1864136;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

>>> src/hbox_if.sv
`timescale 1ns / 1ps

interface hbox_in_if;
    logic                          valid;
    logic                          ready;
    logic [hbox_pkg::SAMPLE_W-1:0] height_sample;
    logic                          drain;

    modport source(output valid, output height_sample, output drain, input ready);
    modport sink(input valid, input height_sample, input drain, output ready);
endinterface

interface hbox_out_if;
    logic                        valid;
    logic                        ready;
    logic [hbox_pkg::MEAN_W-1:0] smoothed_height;
    logic                        last_of_grid;

    modport source(output valid, output smoothed_height, output last_of_grid, input ready);
    modport sink(input valid, input smoothed_height, input last_of_grid, output ready);
endinterface

>>> src/hbox_ram.sv
`timescale 1ns / 1ps

module hbox_ram #(
    parameter int WIDTH = hbox_pkg::LINE_W,
    parameter int DEPTH = hbox_pkg::MAX_COLUMNS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // same-address read and write returns the old word
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

>>> src/hbox_fifo.sv
`timescale 1ns / 1ps

module hbox_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PTR_W = $clog2(hbox_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(hbox_pkg::QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] r_mem [hbox_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [CNT_W-1:0] r_cnt;
    logic             w_push;
    logic             w_pop;

    assign o_full  = (r_cnt == CNT_W'(hbox_pkg::QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= r_wp + PTR_W'(1);
            end
            if (w_pop) begin
                r_rp <= r_rp + PTR_W'(1);
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

endmodule

>>> src/hbox_front.sv
`timescale 1ns / 1ps

module hbox_front #(
    parameter int MAX_COLUMNS = hbox_pkg::MAX_COLUMNS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_restart,
    input  logic [hbox_pkg::COLS_REG_W-1:0]    i_grid_columns,
    input  logic [hbox_pkg::ROWS_REG_W-1:0]    i_grid_rows,
    hbox_in_if.sink                            i_in,
    input  logic                               i_full,
    output logic                               o_push,
    output logic [$clog2(MAX_COLUMNS)-1:0]     o_addr,
    output logic [hbox_pkg::SAMPLE_W-1:0]      o_sample,
    output hbox_pkg::t_opflags                 o_flags
);

    localparam int ADDR_W = $clog2(MAX_COLUMNS);
    localparam int CNT_W  = $clog2(MAX_COLUMNS + 1);
    localparam int ROW_W  = hbox_pkg::ROW_CNT_W;

    logic [ADDR_W-1:0]               r_col;
    logic [ROW_W-1:0]                r_row;
    logic                            r_extra;
    logic [ADDR_W-1:0]               n_col;
    logic [ROW_W-1:0]                n_row;
    logic                            n_extra;

    logic [CNT_W-1:0]                w_cols;
    logic [hbox_pkg::ROWS_REG_W-1:0] w_rows16;
    logic [ROW_W-1:0]                w_rows;
    logic [CNT_W-1:0]                w_col_inc;
    logic                            w_colz;
    logic                            w_complete;
    logic                            w_take;

    always_comb begin
        priority if (i_grid_columns == '0) begin
            w_cols = CNT_W'(1);
        end else if (32'(i_grid_columns) > 32'(MAX_COLUMNS)) begin
            w_cols = CNT_W'(MAX_COLUMNS);
        end else begin
            w_cols = CNT_W'(i_grid_columns);
        end
    end

    assign w_rows16   = (i_grid_rows == '0) ? hbox_pkg::ROWS_REG_W'(1) : i_grid_rows;
    assign w_rows     = ROW_W'(w_rows16);
    assign w_col_inc  = CNT_W'(r_col) + CNT_W'(1);
    assign w_colz     = (r_col == '0);
    assign w_complete = (r_row >= w_rows);

    // The result position trails the input by one row plus one word; at
    // column zero it is the end of the row before last.
    always_comb begin
        o_flags.emit   = (r_row > ROW_W'(1)) || ((r_row == ROW_W'(1)) && !w_colz);
        o_flags.last   = w_colz && (r_row >= w_rows + ROW_W'(1));
        o_flags.row_up = w_colz ? (r_row >= ROW_W'(3)) : (r_row >= ROW_W'(2));
        o_flags.row_dn = w_colz ? (r_row <= w_rows) : (r_row < w_rows);
        o_flags.col_lt = w_colz ? (w_cols >= CNT_W'(2)) : (CNT_W'(r_col) >= CNT_W'(2));
        o_flags.col_rt = !w_colz;
    end

    assign i_in.ready = !r_extra && !i_full;
    assign w_take     = i_in.valid && i_in.ready;
    // once the grid is in, every word only pushes the pipeline with zeros
    assign o_push     = (w_take && (!i_in.drain || w_complete)) || (r_extra && !i_full);
    assign o_sample   = (r_extra || w_complete) ? '0 : i_in.height_sample;
    assign o_addr     = r_col;

    always_comb begin
        n_col   = r_col;
        n_row   = r_row;
        n_extra = r_extra;
        if (o_push) begin
            if (o_flags.last) begin
                n_col = '0;
                n_row = '0;
            end else if (w_col_inc >= w_cols) begin
                n_col = '0;
                n_row = r_row + ROW_W'(1);
            end else begin
                n_col = ADDR_W'(w_col_inc);
            end
        end
        // single-row grid: first drain after the grid needs a second advance
        if (w_take) begin
            n_extra = w_complete && !o_flags.emit;
        end else if (r_extra && !i_full) begin
            n_extra = 1'b0;
        end
        if (i_restart) begin
            n_col   = '0;
            n_row   = '0;
            n_extra = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_extra <= 1'b0;
        end else begin
            r_col   <= n_col;
            r_row   <= n_row;
            r_extra <= n_extra;
        end
    end

endmodule

>>> src/hbox_back.sv
`timescale 1ns / 1ps

module hbox_back #(
    parameter int MAX_COLUMNS = hbox_pkg::MAX_COLUMNS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_q_empty,
    input  logic [$clog2(MAX_COLUMNS)-1:0] i_q_addr,
    input  logic [hbox_pkg::SAMPLE_W-1:0]  i_q_sample,
    input  hbox_pkg::t_opflags             i_q_flags,
    output logic                           o_q_pop,
    hbox_out_if.source                     o_out
);

    localparam int ADDR_W = $clog2(MAX_COLUMNS);
    localparam int SW     = hbox_pkg::SAMPLE_W;
    localparam int LW     = hbox_pkg::LINE_W;
    localparam int SUM_W  = hbox_pkg::SUM_W;
    localparam int CW     = hbox_pkg::COUNT_W;
    localparam int NUM_W  = hbox_pkg::NUM_W;
    localparam int PROD_W = hbox_pkg::NUM_W + hbox_pkg::RECIP_W;

    // stage B: line store data back, window shift and write-back
    logic                     r_b_valid;
    logic [ADDR_W-1:0]        r_b_addr;
    logic [SW-1:0]            r_b_sample;
    hbox_pkg::t_opflags       r_b_flags;
    logic                     r_b_fwd;
    logic [LW-1:0]            r_fwd_data;
    logic [LW-1:0]            w_ram_rdata;
    logic [LW-1:0]            w_line;
    logic [LW-1:0]            w_wdata;
    logic                     w_b_go;

    logic [SW-1:0]            r_win [9];

    // stage C: masked sum and count
    logic                     r_c_valid;
    hbox_pkg::t_opflags       r_c_flags;
    logic                     w_c_go;
    logic [SUM_W-1:0]         w_sum;
    logic [SUM_W-1:0]         w_row_sum [3];
    logic                     w_row_ok [3];
    logic                     w_col_ok [3];
    logic [1:0]               w_rows_n;
    logic [1:0]               w_cols_n;
    logic [CW-1:0]            w_cnt;

    // stage D: divide by the count through a reciprocal
    logic                     r_d_valid;
    logic [SUM_W-1:0]         r_d_sum;
    logic [CW-1:0]            r_d_cnt;
    logic                     r_d_last;
    logic                     w_d_go;
    logic [NUM_W-1:0]         w_num;
    logic [PROD_W-1:0]        w_prod;

    // output register
    logic                     r_o_valid;
    logic [hbox_pkg::MEAN_W-1:0] r_o_mean;
    logic                     r_o_last;

    assign w_d_go  = r_d_valid && (!r_o_valid || o_out.ready);
    assign w_c_go  = r_c_valid && (!r_d_valid || w_d_go);
    // the window feeds stage C, so it only moves when C is free
    assign w_b_go  = r_b_valid && (!r_c_valid || w_c_go);
    assign o_q_pop = !i_q_empty && (!r_b_valid || w_b_go);

    assign w_line  = r_b_fwd ? r_fwd_data : w_ram_rdata;
    assign w_wdata = {w_line[SW-1:0], r_b_sample};

    hbox_ram #(
        .WIDTH (LW),
        .DEPTH (MAX_COLUMNS)
    ) u_lines (
        .i_clk   (i_clk),
        .i_we    (w_b_go),
        .i_waddr (r_b_addr),
        .i_wdata (w_wdata),
        .i_re    (o_q_pop),
        .i_raddr (i_q_addr),
        .o_rdata (w_ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_b_addr   <= i_q_addr;
            r_b_sample <= i_q_sample;
            r_b_flags  <= i_q_flags;
            // the RAM returns the old word when the word ahead writes it now
            r_b_fwd    <= w_b_go && (r_b_addr == i_q_addr);
            r_fwd_data <= w_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_b_go) begin
            for (int r = 0; r < 3; r++) begin
                r_win[r*3]     <= r_win[r*3+1];
                r_win[r*3 + 1] <= r_win[r*3+2];
            end
            r_win[2]  <= w_line[LW-1:SW];
            r_win[5]  <= w_line[SW-1:0];
            r_win[8]  <= r_b_sample;
            r_c_flags <= r_b_flags;
        end
    end

    always_comb begin
        w_row_ok[0] = r_c_flags.row_up;
        w_row_ok[1] = 1'b1;
        w_row_ok[2] = r_c_flags.row_dn;
        w_col_ok[0] = r_c_flags.col_lt;
        w_col_ok[1] = 1'b1;
        w_col_ok[2] = r_c_flags.col_rt;
        for (int r = 0; r < 3; r++) begin
            w_row_sum[r] = '0;
            if (w_row_ok[r]) begin
                w_row_sum[r] = (w_col_ok[0] ? SUM_W'(r_win[r*3])     : SUM_W'(0))
                             + SUM_W'(r_win[r*3 + 1])
                             + (w_col_ok[2] ? SUM_W'(r_win[r*3 + 2]) : SUM_W'(0));
            end
        end
        w_sum    = w_row_sum[0] + w_row_sum[1] + w_row_sum[2];
        w_rows_n = 2'd1 + 2'(r_c_flags.row_up) + 2'(r_c_flags.row_dn);
        w_cols_n = 2'd1 + 2'(r_c_flags.col_lt) + 2'(r_c_flags.col_rt);
        w_cnt    = CW'(w_rows_n) * CW'(w_cols_n);
    end

    always_ff @(posedge i_clk) begin
        if (w_c_go) begin
            r_d_sum  <= w_sum;
            r_d_cnt  <= w_cnt;
            r_d_last <= r_c_flags.last;
        end
    end

    // round to nearest: add half the count before the divide
    assign w_num  = {r_d_sum, {hbox_pkg::FRAC_W{1'b0}}} + NUM_W'(r_d_cnt >> 1);
    assign w_prod = PROD_W'(w_num) * PROD_W'(hbox_pkg::recip(r_d_cnt));

    always_ff @(posedge i_clk) begin
        if (w_d_go) begin
            r_o_mean <= w_prod[hbox_pkg::RECIP_SHIFT +: hbox_pkg::MEAN_W];
            r_o_last <= r_d_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (o_q_pop) begin
                r_b_valid <= 1'b1;
            end else if (w_b_go) begin
                r_b_valid <= 1'b0;
            end
            if (w_b_go) begin
                r_c_valid <= r_b_flags.emit;
            end else if (w_c_go) begin
                r_c_valid <= 1'b0;
            end
            if (w_c_go) begin
                r_d_valid <= 1'b1;
            end else if (w_d_go) begin
                r_d_valid <= 1'b0;
            end
            if (w_d_go) begin
                r_o_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_out.valid           = r_o_valid;
    assign o_out.smoothed_height = r_o_mean;
    assign o_out.last_of_grid    = r_o_last;

endmodule

>>> src/heightmap_box3x3_edge_mean.sv
`timescale 1ns / 1ps
// channel   dir   handshake            word
// i_in      in    valid / ready        height_sample[7:0], drain
// o_out     out   valid / ready        smoothed_height[15:0], last_of_grid
// apb       in    psel/penable/pwrite  paddr[2:0], pwdata[31:0] -> prdata[31:0]
//
// One word per cycle sustained while o_out.ready is high; a result passes
// stages B, C and D after the word that completes it. A single-row grid's
// first drain makes two window advances. Reset (i_rst_n, synchronous) clears
// counters, queue and valids and loads the grid defaults; the line stores
// start unknown and unwritten entries reach masked cells only. Each stage
// stalls on the one after it; the queue decouples input from it.

module heightmap_box3x3_edge_mean #(
    parameter int MAX_COLUMNS = hbox_pkg::MAX_COLUMNS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    hbox_in_if.sink                         i_in,
    hbox_out_if.source                      o_out,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [hbox_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [hbox_pkg::APB_DATA_W-1:0] pwdata,
    output logic [hbox_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);

    localparam int ADDR_W = $clog2(MAX_COLUMNS);
    localparam int SW     = hbox_pkg::SAMPLE_W;
    localparam int FLAG_W = $bits(hbox_pkg::t_opflags);
    localparam int Q_W    = ADDR_W + SW + FLAG_W;

    logic [hbox_pkg::COLS_REG_W-1:0] r_grid_columns;
    logic [hbox_pkg::ROWS_REG_W-1:0] r_grid_rows;
    logic                            w_cfg_wr;

    logic                            w_push;
    logic                            w_full;
    logic [ADDR_W-1:0]               w_addr;
    logic [SW-1:0]                   w_sample;
    hbox_pkg::t_opflags              w_flags;

    logic                            w_pop;
    logic                            w_empty;
    logic [Q_W-1:0]                  w_q_data;
    logic [ADDR_W-1:0]               w_q_addr;
    logic [SW-1:0]                   w_q_sample;
    hbox_pkg::t_opflags              w_q_flags;

    // register file; any write restarts the grid
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_columns <= hbox_pkg::GRID_COLUMNS_RST;
            r_grid_rows    <= hbox_pkg::GRID_ROWS_RST;
        end else if (w_cfg_wr) begin
            unique case (paddr[2])
                hbox_pkg::REG_GRID_COLUMNS:
                    r_grid_columns <= pwdata[hbox_pkg::COLS_REG_W-1:0];
                hbox_pkg::REG_GRID_ROWS:
                    r_grid_rows <= pwdata[hbox_pkg::ROWS_REG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            hbox_pkg::REG_GRID_COLUMNS: prdata = hbox_pkg::APB_DATA_W'(r_grid_columns);
            hbox_pkg::REG_GRID_ROWS:    prdata = hbox_pkg::APB_DATA_W'(r_grid_rows);
            default:                    prdata = '0;
        endcase
    end

    hbox_front #(
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_restart      (w_cfg_wr),
        .i_grid_columns (r_grid_columns),
        .i_grid_rows    (r_grid_rows),
        .i_in           (i_in),
        .i_full         (w_full),
        .o_push         (w_push),
        .o_addr         (w_addr),
        .o_sample       (w_sample),
        .o_flags        (w_flags)
    );

    hbox_fifo #(
        .WIDTH (Q_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  ({w_addr, w_sample, w_flags}),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_data  (w_q_data),
        .o_empty (w_empty)
    );

    assign {w_q_addr, w_q_sample, w_q_flags} = w_q_data;

    hbox_back #(
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_empty  (w_empty),
        .i_q_addr   (w_q_addr),
        .i_q_sample (w_q_sample),
        .i_q_flags  (w_q_flags),
        .o_q_pop    (w_pop),
        .o_out      (o_out)
    );

    a_no_push_when_full: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full
    ) else $error("push into a full queue");

    a_last_is_corner: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (w_push && w_flags.last) |-> (w_flags.emit && !w_flags.row_dn && !w_flags.col_rt)
    ) else $error("end of grid flagged away from the bottom right corner");

    a_mean_range: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.smoothed_height <= hbox_pkg::MEAN_MAX)
    ) else $error("mean out of range");

    a_restart_drops_extra: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        w_cfg_wr |=> !w_push || (i_in.valid && i_in.ready)
    ) else $error("second advance survived a register write");

endmodule
